[rtl/tap_pkg.sv]
// Package: shared types, constants and helpers for the tagged attribute record parser.
`timescale 1ns / 1ps
package tap_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [7:0] OPEN_RST  = 8'd60;
  localparam logic [7:0] CLOSE_RST = 8'd62;
  localparam logic [7:0] EQUAL_RST = 8'd61;
  localparam logic [7:0] QUOTE_RST = 8'd34;
  localparam logic [7:0] SPACE_RST = 8'd32;

  typedef enum logic [2:0] {
    REG_OPEN  = 3'd0,
    REG_CLOSE = 3'd1,
    REG_EQUAL = 3'd2,
    REG_QUOTE = 3'd3,
    REG_SPACE = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_SEEK  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_WS    = 3'd2,
    PH_NAME  = 3'd3,
    PH_QUOTE = 3'd4,
    PH_VALUE = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    K_TYPE_BYTE  = 4'd0,
    K_NAME_BYTE  = 4'd1,
    K_VALUE_BYTE = 4'd2,
    K_TYPE_DONE  = 4'd3,
    K_ATTR_DONE  = 4'd4,
    K_REC_DONE   = 4'd5,
    K_NO_REC     = 4'd6,
    K_UNEXP_END  = 4'd7,
    K_INVALID    = 4'd8
  } kind_t;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    kind_t      token_kind;
    logic [7:0] token_byte;
  } out_word_t;

  typedef struct packed {
    logic [7:0] open_char;
    logic [7:0] close_char;
    logic [7:0] equal_char;
    logic [7:0] quote_char;
    logic [7:0] space_char;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

  typedef struct packed {
    phase_t phase;
    logic   type_seen;
  } fsm_stat_t;

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
  endfunction

endpackage

[rtl/tap_cfg.sv]
// Configuration register file with APB-style write and read access.
`timescale 1ns / 1ps
module tap_cfg
  import tap_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_OPEN:  cfg_nxt.open_char  = pwdata[7:0];
        REG_CLOSE: cfg_nxt.close_char = pwdata[7:0];
        REG_EQUAL: cfg_nxt.equal_char = pwdata[7:0];
        REG_QUOTE: cfg_nxt.quote_char = pwdata[7:0];
        REG_SPACE: cfg_nxt.space_char = pwdata[7:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OPEN:  prdata = {24'd0, cfg_r.open_char};
      REG_CLOSE: prdata = {24'd0, cfg_r.close_char};
      REG_EQUAL: prdata = {24'd0, cfg_r.equal_char};
      REG_QUOTE: prdata = {24'd0, cfg_r.quote_char};
      REG_SPACE: prdata = {24'd0, cfg_r.space_char};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_char  <= OPEN_RST;
      cfg_r.close_char <= CLOSE_RST;
      cfg_r.equal_char <= EQUAL_RST;
      cfg_r.quote_char <= QUOTE_RST;
      cfg_r.space_char <= SPACE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/tap_fsm.sv]
// Parse state machine: phase and type-seen flag, token decode for one byte.
`timescale 1ns / 1ps
module tap_fsm
  import tap_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      word_valid,
  input  in_word_t  word,
  input  logic      go,
  output res_t      res,
  output fsm_stat_t stat
);

  phase_t     phase_r, phase_nxt;
  logic       seen_r, seen_nxt;
  logic [7:0] b;
  logic       ws;

  assign b    = word.in_byte;
  assign ws   = is_ws(word.in_byte);
  assign stat = '{phase: phase_r, type_seen: seen_r};

  // next state
  always_comb begin
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    if (go) begin
      if (word.op) begin
        phase_nxt = PH_SEEK;
      end else begin
        unique case (phase_r)
          PH_TYPE: begin
            if (b == cfg.space_char) begin
              phase_nxt = seen_r ? PH_WS : PH_SEEK;
            end else if (!ws) begin
              seen_nxt = 1'b1;
            end
          end
          PH_WS: begin
            if (!ws) begin
              if (b == cfg.close_char)      phase_nxt = PH_SEEK;
              else if (b == cfg.equal_char) phase_nxt = PH_QUOTE;
              else                          phase_nxt = PH_NAME;
            end
          end
          PH_NAME: begin
            if (b == cfg.space_char)      phase_nxt = PH_SEEK;
            else if (b == cfg.equal_char) phase_nxt = PH_QUOTE;
          end
          PH_QUOTE: begin
            phase_nxt = (b == cfg.quote_char) ? PH_VALUE : PH_SEEK;
          end
          PH_VALUE: begin
            if (b == cfg.quote_char) phase_nxt = PH_WS;
          end
          default: begin
            if (b == cfg.open_char) begin
              phase_nxt = PH_TYPE;
              seen_nxt  = 1'b0;
            end else begin
              phase_nxt = PH_SEEK;
            end
          end
        endcase
      end
    end
  end

  // token output
  always_comb begin
    res = '{valid: 1'b0, word: '{token_kind: K_NO_REC, token_byte: 8'd0}};
    if (word_valid) begin
      if (word.op) begin
        res.valid           = 1'b1;
        res.word.token_kind = (phase_r == PH_SEEK) ? K_NO_REC : K_UNEXP_END;
      end else begin
        unique case (phase_r)
          PH_TYPE: begin
            if (b == cfg.space_char) begin
              res.valid           = 1'b1;
              res.word.token_kind = seen_r ? K_TYPE_DONE : K_INVALID;
            end else if (!ws) begin
              res.valid           = 1'b1;
              res.word.token_kind = K_TYPE_BYTE;
              res.word.token_byte = b;
            end
          end
          PH_WS: begin
            if (!ws) begin
              if (b == cfg.close_char) begin
                res.valid           = 1'b1;
                res.word.token_kind = K_REC_DONE;
              end else if (b != cfg.equal_char) begin
                res.valid           = 1'b1;
                res.word.token_kind = K_NAME_BYTE;
                res.word.token_byte = b;
              end
            end
          end
          PH_NAME: begin
            if (b == cfg.space_char) begin
              res.valid           = 1'b1;
              res.word.token_kind = K_INVALID;
            end else if (b != cfg.equal_char) begin
              res.valid           = 1'b1;
              res.word.token_kind = K_NAME_BYTE;
              res.word.token_byte = b;
            end
          end
          PH_QUOTE: begin
            if (b != cfg.quote_char) begin
              res.valid           = 1'b1;
              res.word.token_kind = K_INVALID;
            end
          end
          PH_VALUE: begin
            res.valid = 1'b1;
            if (b == cfg.quote_char) begin
              res.word.token_kind = K_ATTR_DONE;
            end else begin
              res.word.token_kind = K_VALUE_BYTE;
              res.word.token_byte = b;
            end
          end
          default: res.valid = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      seen_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

[rtl/tagged_attribute_record_parser.sv]
// Top level: input register, parse state machine, output register, config port.
//
// Byte stream in on in_word (op = 0 data byte, op = 1 end of stream), one
// token word out on out_word per byte that yields a token; skipped bytes
// give nothing. A word moves when valid is high and stall is low.
// Throughput: one byte per cycle while in_stall is low; the parse state
// updates as each byte leaves the input register.
// When out_stall holds a token, the input register keeps feeding bytes
// that give no token; the first byte that has a token waits there and
// in_stall rises until the output register frees up.
// Reset clears the parse state to searching for the open byte, empties
// both registers and loads the default delimiter bytes.
// Config registers (byte address 4*i): open, close, equal, quote, space;
// write only while no word is in flight.
`timescale 1ns / 1ps
module tagged_attribute_record_parser
  import tap_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  res_t      res;
  fsm_stat_t stat;

  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_word_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  logic      go;

  tap_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tap_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .word_valid (s1_valid_r),
    .word       (s1_word_r),
    .go         (go),
    .res        (res),
    .stat       (stat)
  );

  assign go           = s1_valid_r & (!res.valid | !out_valid_r | !out_stall);
  assign in_stall     = s1_valid_r & !go;
  assign s1_valid_nxt = in_stall ? s1_valid_r : in_valid;
  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;

  always_comb begin
    if (go && res.valid)        out_valid_nxt = 1'b1;
    else if (!out_stall)        out_valid_nxt = 1'b0;
    else                        out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) s1_word_r <= in_word;
    if (go && res.valid) out_word_r <= res.word;
  end

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && res.valid && out_valid_r && out_stall))
    else $error("input stalled without a blocked token");

  a_end_to_seek: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res.valid && (res.word.token_kind == K_REC_DONE ||
      res.word.token_kind == K_INVALID || res.word.token_kind == K_UNEXP_END ||
      res.word.token_kind == K_NO_REC)) |=> (stat.phase == PH_SEEK))
    else $error("record end did not return to seek");

  a_type_done_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res.valid && res.word.token_kind == K_TYPE_DONE) |-> stat.type_seen)
    else $error("type done without a type byte");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.token_kind != K_TYPE_BYTE &&
      out_word.token_kind != K_NAME_BYTE && out_word.token_kind != K_VALUE_BYTE)
      |-> (out_word.token_byte == 8'd0))
    else $error("nonzero byte on a control token");

endmodule

[tb/sv/tagged_attribute_record_parser_tb.sv]
// Testbench for the record parser: streams bytes under several delimiter settings and checks tokens.
`timescale 1ns / 1ps
module tagged_attribute_record_parser_tb;
  import tap_pkg::*;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;
  localparam int N_REGS          = 5;
  localparam int N_PHASES        = 8;
  localparam int WORDS_PER_PHASE = 160;
  localparam int SETTLE_CYCLES   = 4;
  localparam int MAX_REPORTS     = 200;

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    logic      has;
    out_word_t tok;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_word;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_word;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // parser shadow state
  cfg_t   delim;
  phase_t parse_ph;
  logic   type_seen;

  out_word_t token_q[$];
  in_word_t  stream_q[$];
  dir_row_t  dir_tab[$];
  int        errors = 0;
  int        words_sent = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      drv_typed = 1'b0;
  logic      drv_has = 1'b0;
  out_word_t drv_tok;

  tagged_attribute_record_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic is_blank(input logic [7:0] b);
    return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
  endfunction

  function automatic void parse_byte(input in_word_t w, output logic has, output out_word_t tok);
    logic [7:0] b;
    b = w.in_byte;
    has = 1'b0;
    tok.token_kind = K_NO_REC;
    tok.token_byte = 8'd0;
    if (w.op == OP_END) begin
      has = 1'b1;
      tok.token_kind = (parse_ph == PH_SEEK) ? K_NO_REC : K_UNEXP_END;
      parse_ph = PH_SEEK;
      return;
    end
    case (parse_ph)
      PH_TYPE: begin
        if (b == delim.space_char) begin
          has = 1'b1;
          tok.token_kind = type_seen ? K_TYPE_DONE : K_INVALID;
          parse_ph = type_seen ? PH_WS : PH_SEEK;
        end else if (!is_blank(b)) begin
          type_seen = 1'b1;
          has = 1'b1;
          tok.token_kind = K_TYPE_BYTE;
          tok.token_byte = b;
        end
      end
      PH_WS: begin
        if (!is_blank(b)) begin
          if (b == delim.close_char) begin
            has = 1'b1;
            tok.token_kind = K_REC_DONE;
            parse_ph = PH_SEEK;
          end else if (b == delim.equal_char) begin
            parse_ph = PH_QUOTE;
          end else begin
            has = 1'b1;
            tok.token_kind = K_NAME_BYTE;
            tok.token_byte = b;
            parse_ph = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (b == delim.space_char) begin
          has = 1'b1;
          tok.token_kind = K_INVALID;
          parse_ph = PH_SEEK;
        end else if (b == delim.equal_char) begin
          parse_ph = PH_QUOTE;
        end else begin
          has = 1'b1;
          tok.token_kind = K_NAME_BYTE;
          tok.token_byte = b;
        end
      end
      PH_QUOTE: begin
        if (b != delim.quote_char) begin
          has = 1'b1;
          tok.token_kind = K_INVALID;
          parse_ph = PH_SEEK;
        end else begin
          parse_ph = PH_VALUE;
        end
      end
      PH_VALUE: begin
        has = 1'b1;
        if (b == delim.quote_char) begin
          tok.token_kind = K_ATTR_DONE;
          parse_ph = PH_WS;
        end else begin
          tok.token_kind = K_VALUE_BYTE;
          tok.token_byte = b;
        end
      end
      default: begin
        if (b == delim.open_char) begin
          parse_ph = PH_TYPE;
          type_seen = 1'b0;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    logic      has;
    out_word_t tok;
    out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        parse_byte(in_word, has, tok);
        if (drv_typed) begin
          has = drv_has;
          tok = drv_tok;
        end
        if (has) token_q.push_back(tok);
      end
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected token, expected none, got kind %0d byte %02h",
                     $time, out_word.token_kind, out_word.token_byte);
        end else begin
          want = token_q.pop_front();
          if (out_word.token_kind !== want.token_kind ||
              out_word.token_byte !== want.token_byte) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: expected kind %0d byte %02h, got kind %0d byte %02h", $time,
                       want.token_kind, want.token_byte, out_word.token_kind,
                       out_word.token_byte);
          end
        end
      end
    end
  end

  task automatic push_word(input in_word_t w, input logic typed, input logic has,
                           input out_word_t tok);
    @(negedge clk);
    drv_typed = typed;
    drv_has = has;
    drv_tok = tok;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_word <= 9'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input int idx, input logic [7:0] wdata,
                          output logic [7:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CFG_AW'(4 * idx);
    pwdata <= CFG_DW'(wdata);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata[7:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_write(input int idx, input logic [7:0] v);
    logic [7:0] unused;
    apb_xfer(1'b1, idx, v, unused);
    case (idx)
      REG_OPEN:  delim.open_char = v;
      REG_CLOSE: delim.close_char = v;
      REG_EQUAL: delim.equal_char = v;
      REG_QUOTE: delim.quote_char = v;
      REG_SPACE: delim.space_char = v;
      default: ;
    endcase
  endtask

  task automatic check_regs();
    logic [7:0] got;
    for (int i = 0; i < N_REGS; i++) begin
      apb_xfer(1'b0, i, 8'd0, got);
      if (got !== delim[8*(N_REGS-1-i) +: 8]) begin
        errors++;
        $display("%0t: register %0d expected %02h, got %02h", $time, i,
                 delim[8*(N_REGS-1-i) +: 8], got);
      end
    end
  endtask

  task automatic load_cfg(input cfg_t c);
    cfg_write(REG_OPEN, c.open_char);
    cfg_write(REG_CLOSE, c.close_char);
    cfg_write(REG_EQUAL, c.equal_char);
    cfg_write(REG_QUOTE, c.quote_char);
    cfg_write(REG_SPACE, c.space_char);
    // unmapped index, must be ignored
    cfg_write($urandom_range(7, N_REGS), 8'($urandom));
    check_regs();
  endtask

  function automatic cfg_t pick_cfg(input int ph);
    cfg_t c;
    c = {OPEN_RST, CLOSE_RST, EQUAL_RST, QUOTE_RST, SPACE_RST};
    case (ph)
      0: ;
      1: c = '0;
      2: c = '1;
      3: c = {8'h28, 8'h3D, 8'h3D, 8'h27, 8'h53};  // close == equal, non-blank space byte
      4: c = {8'h22, 8'h00, 8'h3A, 8'h22, 8'h09};  // open == quote, tab ends the type
      default: begin
        for (int i = 0; i < N_REGS; i++)
          if ($urandom_range(1))
            c[8*i +: 8] = (ph % 2) ? 8'($urandom) : c[8*$urandom_range(N_REGS-1) +: 8];
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [7:0] x, input logic [7:0] y,
                                           input logic no_blank);
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == x || b == y || (no_blank && is_blank(b)));
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(5) == 5) ? 8'd32 : 8'(9 + $urandom_range(4));
  endfunction

  task automatic put(input logic op, input logic [7:0] b);
    in_word_t w;
    w.op = op;
    w.in_byte = b;
    stream_q.push_back(w);
  endtask

  task automatic tab_exp(input logic op, input logic [7:0] b, input logic has, input kind_t k);
    dir_row_t r;
    r.w.op = op;
    r.w.in_byte = b;
    r.typed = 1'b1;
    r.has = has;
    r.tok.token_kind = k;
    r.tok.token_byte = 8'd0;
    dir_tab.push_back(r);
  endtask

  task automatic tab_pred(input logic op, input logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.w.op = op;
    r.w.in_byte = b;
    dir_tab.push_back(r);
  endtask

  // mostly well-formed records with random content, some cut short, some noise
  task automatic build_sequence();
    int n;
    int cut;
    stream_q.delete();
    if ($urandom_range(9) < 2) begin
      repeat ($urandom_range(12, 1))
        put(($urandom_range(9) == 0) ? OP_END : OP_DATA, 8'($urandom));
      return;
    end
    repeat ($urandom_range(2)) put(OP_DATA, pick_byte(delim.open_char, delim.open_char, 1'b0));
    put(OP_DATA, delim.open_char);
    repeat ($urandom_range(4, 1)) begin
      if ($urandom_range(7) == 0) put(OP_DATA, blank_byte());
      put(OP_DATA, pick_byte(delim.space_char, delim.space_char, 1'b1));
    end
    put(OP_DATA, delim.space_char);
    repeat ($urandom_range(3)) begin
      repeat ($urandom_range(2)) put(OP_DATA, blank_byte());
      n = $urandom_range(4);
      for (int i = 0; i < n; i++)
        put(OP_DATA, (i == 0) ? pick_byte(delim.close_char, delim.equal_char, 1'b1)
                              : pick_byte(delim.space_char, delim.equal_char, 1'b0));
      put(OP_DATA, delim.equal_char);
      put(OP_DATA, delim.quote_char);
      repeat ($urandom_range(5)) put(OP_DATA, pick_byte(delim.quote_char, delim.quote_char, 1'b0));
      put(OP_DATA, delim.quote_char);
    end
    repeat ($urandom_range(1)) put(OP_DATA, blank_byte());
    put(OP_DATA, delim.close_char);
    if ($urandom_range(4) == 0) begin
      cut = $urandom_range(stream_q.size() - 1);
      while (stream_q.size() > cut) void'(stream_q.pop_back());
      put($urandom_range(1) ? OP_END : OP_DATA, 8'($urandom));
    end else if ($urandom_range(9) == 0) begin
      put(OP_END, 8'($urandom));
    end
  endtask

  initial begin
    #(3_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int base;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    drv_tok = '0;
    delim = {OPEN_RST, CLOSE_RST, EQUAL_RST, QUOTE_RST, SPACE_RST};
    parse_ph = PH_SEEK;
    type_seen = 1'b0;

    tab_exp(OP_END, 8'hFF, 1'b1, K_NO_REC);
    tab_exp(OP_DATA, 8'hFF, 1'b0, K_NO_REC);
    tab_exp(OP_DATA, "<", 1'b0, K_NO_REC);
    tab_exp(OP_DATA, " ", 1'b1, K_INVALID);     // empty type
    tab_pred(OP_DATA, "<");
    tab_pred(OP_DATA, "a");
    tab_pred(OP_DATA, 8'h09);
    tab_pred(OP_DATA, " ");
    tab_pred(OP_DATA, "n");
    tab_pred(OP_DATA, "=");
    tab_pred(OP_DATA, 8'h22);
    tab_pred(OP_DATA, 8'hFF);
    tab_pred(OP_DATA, 8'h22);
    tab_pred(OP_DATA, "=");                     // empty name
    tab_pred(OP_DATA, 8'h22);
    tab_pred(OP_DATA, 8'h22);
    tab_pred(OP_DATA, ">");
    tab_pred(OP_DATA, "<");
    tab_pred(OP_DATA, "x");
    tab_pred(OP_DATA, " ");
    tab_pred(OP_DATA, "k");
    tab_exp(OP_DATA, " ", 1'b1, K_INVALID);     // space inside a name
    tab_pred(OP_DATA, "<");
    tab_pred(OP_DATA, "x");
    tab_pred(OP_DATA, " ");
    tab_pred(OP_DATA, "=");
    tab_exp(OP_DATA, "<", 1'b1, K_INVALID);     // missing quote, byte is consumed
    tab_exp(OP_DATA, "q", 1'b0, K_NO_REC);
    tab_pred(OP_DATA, "<");
    tab_exp(OP_END, 8'h00, 1'b1, K_UNEXP_END);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_regs();
    foreach (dir_tab[i]) push_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].has, dir_tab[i].tok);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      load_cfg(pick_cfg(ph));
      base = words_sent;
      while (words_sent - base < WORDS_PER_PHASE) begin
        build_sequence();
        foreach (stream_q[i]) push_word(stream_q[i], 1'b0, 1'b0, '0);
      end
    end
    drain();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
